/* rtl/tbs_pkg.sv */
// Shared types and constants of the texture bilinear sampler.
// Used by the channel interfaces, the top level and the testbench.
package tbs_pkg;

    // Default sizes of the texture store.
    localparam int DEF_MAX_WIDTH    = 128;
    localparam int DEF_MAX_HEIGHT   = 128;
    localparam int DEF_MAX_CHANNELS = 4;

    // Configuration port.
    localparam int CFG_DATA_W = 8;
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WIDTH    = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT   = 2'd1;
    localparam t_cfg_idx CFG_CHANNELS = 2'd2;

    // Register reset values.
    localparam logic [7:0] RST_WIDTH    = 8'd128;
    localparam logic [7:0] RST_HEIGHT   = 8'd128;
    localparam logic [2:0] RST_CHANNELS = 3'd3;

    // Fixed point: a weight of 1.0 is 256, a full blend is 65536.
    localparam logic [8:0] WGT_ONE = 9'd256;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    // Request beat.
    typedef struct packed {
        t_action    action;
        logic [6:0] x_index;
        logic [6:0] y_index;
        logic [8:0] frac_x;
        logic [8:0] frac_y;
        logic       smooth;
        logic [1:0] write_channel;
        logic [7:0] write_value;
    } t_req;

    // Response beat.
    typedef struct packed {
        logic [23:0] chan0_value;
        logic [23:0] chan1_value;
        logic [23:0] chan2_value;
        logic [23:0] chan3_value;
        logic [2:0]  channels_valid;
        logic        range_error;
    } t_rsp;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

/* rtl/tbs_req_if.sv */
// Request channel of the texture sampler: valid, ready and a request beat.
// Depends on tbs_pkg for the payload type.
interface tbs_req_if;
    import tbs_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/tbs_rsp_if.sv */
// Response channel of the texture sampler: valid, ready and a response beat.
// Depends on tbs_pkg for the payload type.
interface tbs_rsp_if;
    import tbs_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/tbs_texel_ram.sv */
// Byte-wide texel memory with one write port and two registered read ports.
// Stand-alone; the top level instantiates one copy per neighborhood row.
module tbs_texel_ram #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [7:0]    o_rdata_a,
    output logic [7:0]    o_rdata_b
);
    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata_a;
    logic [7:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

/* rtl/texture_bilinear_sampler_unit.sv */
// Texture sampler over planar 8-bit channels with nearest and bilinear modes.
// Depends on tbs_pkg, tbs_req_if, tbs_rsp_if and tbs_texel_ram.
//
// A write beat stores one texel byte if it lies inside the image and its
// channel is in use; it gives no response. A sample beat inside the image
// goes through the issue, drain and done states, and the next beat is taken
// only back in idle: the store is kept as two identical copies, one for the
// upper and one for the lower row of the 2x2 neighborhood, each with two read
// ports, so one channel's four texels are read per cycle and the channels are
// read one after the other, followed by a two-stage multiply and sum pipeline,
// a drain state that waits for it to empty and a done state that loads the
// output once the output register is free. A sample outside the image, or
// with zero channels, goes straight to the done state. Results are
// unnormalized: full scale is 255 * 65536. The response sits in an output
// register, so a new request is taken while it waits. The store needs no
// clearing after reset; texels must be written before they are read.
module texture_bilinear_sampler_unit #(
    parameter int MAX_WIDTH    = tbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = tbs_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = tbs_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  tbs_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    tbs_req_if.sink                         i_req,
    tbs_rsp_if.source                       o_rsp
);
    import tbs_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW = CW + YW + XW;
    localparam logic [7:0] W_LIM = (MAX_WIDTH > 255) ? 8'd255 : 8'(MAX_WIDTH);
    localparam logic [7:0] H_LIM = (MAX_HEIGHT > 255) ? 8'd255 : 8'(MAX_HEIGHT);
    localparam logic [2:0] C_LIM = 3'(MAX_CHANNELS);

    // Configuration registers.
    logic [7:0] r_cfg_w;
    logic [7:0] r_cfg_h;
    logic [2:0] r_cfg_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
            r_cfg_c <= RST_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:    r_cfg_w <= i_cfg_wdata[7:0];
                CFG_HEIGHT:   r_cfg_h <= i_cfg_wdata[7:0];
                CFG_CHANNELS: r_cfg_c <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Sizes in effect, limited to what the store holds.
    logic [7:0] eff_w;
    logic [7:0] eff_h;
    logic [2:0] eff_c;

    assign eff_w = (r_cfg_w > W_LIM) ? W_LIM : r_cfg_w;
    assign eff_h = (r_cfg_h > H_LIM) ? H_LIM : r_cfg_h;
    assign eff_c = (r_cfg_c > C_LIM) ? C_LIM : r_cfg_c;

    t_state r_state;
    t_state n_state;

    // Request decode.
    t_req       req;
    logic       acc;
    logic       acc_wr;
    logic       acc_smp;
    logic [7:0] x8;
    logic [7:0] y8;
    logic [7:0] x_next;
    logic [7:0] y_next;
    logic [7:0] x1;
    logic [7:0] y1;
    logic       in_image;
    logic [8:0] fx;
    logic [8:0] fy;
    logic [8:0] gx;
    logic [8:0] gy;

    assign req      = i_req.payload;
    assign acc      = i_req.valid && i_req.ready;
    assign acc_wr   = acc && (req.action == ACT_WRITE);
    assign acc_smp  = acc && (req.action == ACT_SAMPLE);
    assign x8       = {1'b0, req.x_index};
    assign y8       = {1'b0, req.y_index};
    assign in_image = (x8 < eff_w) && (y8 < eff_h);
    assign x_next   = x8 + 8'd1;
    assign y_next   = y8 + 8'd1;

    // Right and lower neighbors wrap at the edge; nearest mode reads its own texel.
    assign x1 = !req.smooth ? x8 : ((x_next == eff_w) ? 8'd0 : x_next);
    assign y1 = !req.smooth ? y8 : ((y_next == eff_h) ? 8'd0 : y_next);

    // Weights saturate at 1.0; nearest mode weights only the home texel.
    assign fx = !req.smooth ? 9'd0 : ((req.frac_x > WGT_ONE) ? WGT_ONE : req.frac_x);
    assign fy = !req.smooth ? 9'd0 : ((req.frac_y > WGT_ONE) ? WGT_ONE : req.frac_y);
    assign gx = WGT_ONE - fx;
    assign gy = WGT_ONE - fy;

    // Corner weights in units of 1/65536.
    logic [16:0] fx17;
    logic [16:0] fy17;
    logic [16:0] gx17;
    logic [16:0] gy17;
    logic [16:0] wgt [4];

    assign fx17   = {8'd0, fx};
    assign fy17   = {8'd0, fy};
    assign gx17   = {8'd0, gx};
    assign gy17   = {8'd0, gy};
    assign wgt[0] = gx17 * gy17;
    assign wgt[1] = fx17 * gy17;
    assign wgt[2] = gx17 * fy17;
    assign wgt[3] = fx17 * fy17;

    // Coordinates cut to the address fields of the store.
    logic [XW+7:0] x0_wide;
    logic [XW+7:0] x1_wide;
    logic [YW+7:0] y0_wide;
    logic [YW+7:0] y1_wide;
    logic [CW+1:0] wc_wide;

    assign x0_wide = {{XW{1'b0}}, x8};
    assign x1_wide = {{XW{1'b0}}, x1};
    assign y0_wide = {{YW{1'b0}}, y8};
    assign y1_wide = {{YW{1'b0}}, y1};
    assign wc_wide = {{CW{1'b0}}, req.write_channel};

    // Sample context held for the whole item.
    logic [XW-1:0] r_x0;
    logic [XW-1:0] r_x1;
    logic [YW-1:0] r_y0;
    logic [YW-1:0] r_y1;
    logic [16:0]   r_wgt [4];
    logic          r_in_image;
    logic [2:0]    r_nc;
    logic [1:0]    r_ch;

    always_ff @(posedge i_clk) begin
        if (acc_smp) begin
            r_x0       <= x0_wide[XW-1:0];
            r_x1       <= x1_wide[XW-1:0];
            r_y0       <= y0_wide[YW-1:0];
            r_y1       <= y1_wide[YW-1:0];
            r_wgt      <= wgt;
            r_in_image <= in_image;
            r_nc       <= eff_c;
        end
    end

    // Channel counter for read issue.
    always_ff @(posedge i_clk) begin
        if (acc_smp) begin
            r_ch <= 2'd0;
        end else if (r_state == ST_ISSUE) begin
            r_ch <= r_ch + 2'd1;
        end
    end

    logic last_ch;
    assign last_ch = ({1'b0, r_ch} + 3'd1) == r_nc;

    // Texel store: one copy for each neighborhood row.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [CW+1:0] ch_wide;
    logic [CW-1:0] rd_ch;
    logic [7:0]    rd [4];

    assign wr_en   = acc_wr && in_image && ({1'b0, req.write_channel} < eff_c);
    assign wr_addr = {wc_wide[CW-1:0], y0_wide[YW-1:0], x0_wide[XW-1:0]};
    assign rd_en   = (r_state == ST_ISSUE);
    assign ch_wide = {{CW{1'b0}}, r_ch};
    assign rd_ch   = ch_wide[CW-1:0];

    tbs_texel_ram #(.AW(AW)) u_row0 (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (req.write_value),
        .i_re      (rd_en),
        .i_raddr_a ({rd_ch, r_y0, r_x0}),
        .i_raddr_b ({rd_ch, r_y0, r_x1}),
        .o_rdata_a (rd[0]),
        .o_rdata_b (rd[1])
    );

    tbs_texel_ram #(.AW(AW)) u_row1 (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (req.write_value),
        .i_re      (rd_en),
        .i_raddr_a ({rd_ch, r_y1, r_x0}),
        .i_raddr_b ({rd_ch, r_y1, r_x1}),
        .o_rdata_a (rd[2]),
        .o_rdata_b (rd[3])
    );

    // Blend pipeline: read data, weighted products, sum into the channel slot.
    logic        r_v1;
    logic        r_v2;
    logic [1:0]  r_c1;
    logic [1:0]  r_c2;
    logic [23:0] r_prod [4];
    logic [23:0] prod [4];
    logic [23:0] r_res [4];

    // A texel times a corner weight stays below 2**24.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = {16'd0, rd[k]} * {7'd0, r_wgt[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1 <= r_ch;
        r_c2 <= r_c1;
        if (r_v1) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= prod[k];
            end
        end
    end

    // Channel results; unused channels stay zero.
    always_ff @(posedge i_clk) begin
        if (acc_smp) begin
            for (int k = 0; k < 4; k++) begin
                r_res[k] <= 24'd0;
            end
        end else if (r_v2) begin
            r_res[r_c2] <= r_prod[0] + r_prod[1] + r_prod[2] + r_prod[3];
        end
    end

    // Output register.
    logic r_out_valid;
    t_rsp r_out;
    logic out_load;

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.chan0_value    <= r_res[0];
            r_out.chan1_value    <= r_res[1];
            r_out.chan2_value    <= r_res[2];
            r_out.chan3_value    <= r_res[3];
            r_out.channels_valid <= r_nc;
            r_out.range_error    <= !r_in_image;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and request handshake.
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && (req.action == ACT_SAMPLE)) begin
                    n_state = (in_image && (eff_c != 3'd0)) ? ST_ISSUE : ST_DONE;
                end
            end
            ST_ISSUE: begin
                if (last_ch) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    // The pipeline is empty when the response is built.
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_v1 && !r_v2))
        else $error("response built while blend pipeline busy");

    // Only channels in use are read.
    a_chan_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> ({1'b0, r_c1} < r_nc))
        else $error("read issued for a channel not in use");

    // A sample outside the image skips the store.
    a_range_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_smp && !in_image) |=> (r_state == ST_DONE))
        else $error("out of range sample entered the read sequence");

    // A waiting response is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_rsp.ready) |=> (r_state == ST_DONE))
        else $error("pending response overwritten");
`endif
endmodule

/* tb/texture_bilinear_sampler_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of texture_bilinear_sampler_unit: a directed table, then random beats.
// Depends on tbs_pkg, tbs_req_if, tbs_rsp_if and the sampler RTL.
module texture_bilinear_sampler_unit_tb;
    import tbs_pkg::*;

    localparam int unsigned MAXW = DEF_MAX_WIDTH;
    localparam int unsigned MAXH = DEF_MAX_HEIGHT;
    localparam int unsigned MAXC = DEF_MAX_CHANNELS;
    localparam int SETTLE_CYCLES = 16;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 70;
    localparam int TIMEOUT_NS = 5_000_000;

    typedef enum logic {
        ROW_REG,
        ROW_BEAT
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_cfg_idx   idx;
        logic [7:0] value;
        t_req       beat;
        bit         typed;
        t_rsp       want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    t_cfg_idx cfg_idx = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic req_valid = 1'b0;
    t_req req_beat = '0;
    logic sink_ready = 1'b0;

    tbs_req_if req_if ();
    tbs_rsp_if rsp_if ();

    assign req_if.valid = req_valid;
    assign req_if.payload = req_beat;
    assign rsp_if.ready = sink_ready;

    texture_bilinear_sampler_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Mirror of the texture store and of the registers.
    logic [7:0] texel_mirror [0:MAXC-1][0:MAXH-1][0:MAXW-1];
    bit texel_known [0:MAXC-1][0:MAXH-1][0:MAXW-1];
    logic [7:0] reg_width = RST_WIDTH;
    logic [7:0] reg_height = RST_HEIGHT;
    logic [2:0] reg_channels = RST_CHANNELS;
    int unsigned act_w = MAXW;
    int unsigned act_h = MAXH;
    int unsigned act_nc = 3;

    t_rsp awaited_samples [$];
    t_stim_row stim_rows [$];
    int error_count = 0;
    int unsigned accepted_items = 0;
    bit src_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    int unsigned stall_left = 0;
    t_rsp want_rsp;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Neighbor index with wrap to zero at the image edge.
    function automatic int unsigned next_wrap(input int unsigned v, input int unsigned lim);
        return (v + 1 == lim) ? 0 : v + 1;
    endfunction

    // Expected response of a sample beat under the current registers and store.
    function automatic t_rsp blend_texels(input t_req beat);
        t_rsp res;
        logic [23:0] lane [4];
        int unsigned fx, fy, gx, gy, x0, y0, x1, y1, acc, c;
        res = '0;
        for (c = 0; c < 4; c++) lane[c] = '0;
        fx = (beat.frac_x > WGT_ONE) ? WGT_ONE : beat.frac_x;
        fy = (beat.frac_y > WGT_ONE) ? WGT_ONE : beat.frac_y;
        gx = WGT_ONE - fx;
        gy = WGT_ONE - fy;
        x0 = beat.x_index;
        y0 = beat.y_index;
        res.channels_valid = 3'(act_nc);
        if (x0 >= act_w || y0 >= act_h) begin
            res.range_error = 1'b1;
        end else begin
            x1 = next_wrap(x0, act_w);
            y1 = next_wrap(y0, act_h);
            for (c = 0; c < act_nc; c++) begin
                if (beat.smooth) begin
                    acc = texel_mirror[c][y0][x0] * gx * gy
                        + texel_mirror[c][y0][x1] * fx * gy
                        + texel_mirror[c][y1][x0] * gx * fy
                        + texel_mirror[c][y1][x1] * fx * fy;
                end else begin
                    acc = texel_mirror[c][y0][x0] * 65536;
                end
                lane[c] = acc[23:0];
            end
        end
        res.chan0_value = lane[0];
        res.chan1_value = lane[1];
        res.chan2_value = lane[2];
        res.chan3_value = lane[3];
        return res;
    endfunction

    // Write beat; the fields a write does not use get random values.
    function automatic t_req texel_write_beat(input int unsigned ch, input int unsigned x,
                                              input int unsigned y, input int unsigned v);
        t_req b;
        b.action = ACT_WRITE;
        b.x_index = 7'(x);
        b.y_index = 7'(y);
        b.frac_x = 9'($urandom_range(0, 511));
        b.frac_y = 9'($urandom_range(0, 511));
        b.smooth = 1'($urandom_range(0, 1));
        b.write_channel = 2'(ch);
        b.write_value = 8'(v);
        return b;
    endfunction

    function automatic t_req sample_beat(input int unsigned x, input int unsigned y,
                                         input int unsigned fx, input int unsigned fy,
                                         input bit sm);
        t_req b;
        b.action = ACT_SAMPLE;
        b.x_index = 7'(x);
        b.y_index = 7'(y);
        b.frac_x = 9'(fx);
        b.frac_y = 9'(fy);
        b.smooth = sm;
        b.write_channel = 2'($urandom_range(0, 3));
        b.write_value = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic t_rsp mk_rsp(input logic [23:0] c0, input logic [23:0] c1,
                                    input logic [23:0] c2, input logic [23:0] c3,
                                    input logic [2:0] nv, input logic err);
        t_rsp r;
        r.chan0_value = c0;
        r.chan1_value = c1;
        r.chan2_value = c2;
        r.chan3_value = c3;
        r.channels_valid = nv;
        r.range_error = err;
        return r;
    endfunction

    // Weights: mostly in range, with the ends and saturating values mixed in.
    function automatic int unsigned pick_weight();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return WGT_ONE;
        if (r == 2) return $urandom_range(257, 511);
        return $urandom_range(0, 256);
    endfunction

    function automatic void add_beat(input t_req b, input bit typed, input t_rsp want);
        t_stim_row row;
        row.kind = ROW_BEAT;
        row.idx = CFG_WIDTH;
        row.value = '0;
        row.beat = b;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input logic [7:0] value);
        t_stim_row row;
        row.kind = ROW_REG;
        row.idx = idx;
        row.value = value;
        row.beat = '0;
        row.typed = 1'b0;
        row.want = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void match_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Present one request beat, with an optional idle burst first, until it is taken.
    task automatic send_beat(input t_req beat, input bit typed, input t_rsp typed_rsp);
        int unsigned gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_beat <= beat;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        // The beat was taken at this edge: update the mirror or queue the answer.
        if (beat.action == ACT_SAMPLE) begin
            awaited_samples.push_back(typed ? typed_rsp : blend_texels(beat));
        end else if (beat.x_index < act_w && beat.y_index < act_h
                     && beat.write_channel < act_nc) begin
            texel_mirror[beat.write_channel][beat.y_index][beat.x_index] = beat.write_value;
            texel_known[beat.write_channel][beat.y_index][beat.x_index] = 1'b1;
        end
        accepted_items++;
    endtask

    // Drop valid and wait for every awaited response.
    task automatic drain_responses();
        req_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_samples.size() != 0);
    endtask

    // Register write while the block is idle.
    task automatic program_reg(input t_cfg_idx idx, input logic [7:0] value);
        int unsigned c, y, x;
        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH: reg_width = value;
            CFG_HEIGHT: reg_height = value;
            CFG_CHANNELS: reg_channels = value[2:0];
            default: ;
        endcase
        act_w = (reg_width > MAXW) ? MAXW : reg_width;
        act_h = (reg_height > MAXH) ? MAXH : reg_height;
        act_nc = (reg_channels > MAXC) ? MAXC : reg_channels;
        // Texels that leave the image must be written again before they are read.
        for (c = 0; c < MAXC; c++)
            for (y = 0; y < MAXH; y++)
                for (x = 0; x < MAXW; x++)
                    if (c >= act_nc || y >= act_h || x >= act_w) texel_known[c][y][x] = 1'b0;
    endtask

    // Write every texel that a sample at (x, y) reads and that holds no known value.
    task automatic fill_neighborhood(input int unsigned x, input int unsigned y, input bit sm);
        int unsigned xs [2];
        int unsigned ys [2];
        int unsigned c, i, j;
        if (x >= act_w || y >= act_h) return;
        xs[0] = x;
        ys[0] = y;
        xs[1] = sm ? next_wrap(x, act_w) : x;
        ys[1] = sm ? next_wrap(y, act_h) : y;
        for (c = 0; c < act_nc; c++)
            for (i = 0; i < 2; i++)
                for (j = 0; j < 2; j++)
                    if (!texel_known[c][ys[i]][xs[j]])
                        send_beat(texel_write_beat(c, xs[j], ys[i], $urandom_range(0, 255)),
                                  1'b0, '0);
    endtask

    // Response side: check each beat against the oldest expectation, stall in bursts.
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_samples.size() == 0) begin
                $display("%0t: response beat with none awaited: %h", $time, rsp_if.payload);
                error_count++;
            end else begin
                want_rsp = awaited_samples.pop_front();
                match_field("chan0_value", want_rsp.chan0_value, rsp_if.payload.chan0_value);
                match_field("chan1_value", want_rsp.chan1_value, rsp_if.payload.chan1_value);
                match_field("chan2_value", want_rsp.chan2_value, rsp_if.payload.chan2_value);
                match_field("chan3_value", want_rsp.chan3_value, rsp_if.payload.chan3_value);
                match_field("channels_valid", 24'(want_rsp.channels_valid),
                            24'(rsp_if.payload.channels_valid));
                match_field("range_error", 24'(want_rsp.range_error),
                            24'(rsp_if.payload.range_error));
            end
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        sink_ready <= (stall_left == 0) && i_rst_n;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_stim_row row;
        int phase, pick, r;
        int unsigned x, y, bx, by, phase_end;
        bit sm, drained;
        logic [7:0] w_val, h_val;
        logic [2:0] nc_val;

        // Directed table; the typed answers follow from the texels written just before.
        add_beat(texel_write_beat(0, 0, 0, 255), 1'b0, '0);
        add_beat(texel_write_beat(1, 0, 0, 0), 1'b0, '0);
        add_beat(texel_write_beat(2, 0, 0, 128), 1'b0, '0);
        add_beat(sample_beat(0, 0, 0, 0, 1'b0), 1'b1,
                 mk_rsp(24'hFF0000, 24'h0, 24'h800000, 24'h0, 3'd3, 1'b0));
        // A channel beyond the count is not stored.
        add_beat(texel_write_beat(3, 0, 0, 77), 1'b0, '0);
        add_beat(sample_beat(0, 0, 511, 511, 1'b0), 1'b1,
                 mk_rsp(24'hFF0000, 24'h0, 24'h800000, 24'h0, 3'd3, 1'b0));
        add_reg(CFG_CHANNELS, 8'd1);
        add_beat(texel_write_beat(0, 127, 127, 200), 1'b0, '0);
        add_beat(texel_write_beat(0, 0, 127, 10), 1'b0, '0);
        add_beat(texel_write_beat(0, 127, 0, 1), 1'b0, '0);
        // Bottom right corner: both neighbors wrap to zero.
        add_beat(sample_beat(127, 127, 256, 256, 1'b1), 1'b1,
                 mk_rsp(24'hFF0000, 24'h0, 24'h0, 24'h0, 3'd1, 1'b0));
        add_beat(sample_beat(127, 127, 0, 0, 1'b1), 1'b1,
                 mk_rsp(24'hC80000, 24'h0, 24'h0, 24'h0, 3'd1, 1'b0));
        add_beat(sample_beat(127, 127, 100, 37, 1'b1), 1'b0, '0);
        // Weights above one saturate.
        add_beat(sample_beat(127, 127, 300, 511, 1'b1), 1'b1,
                 mk_rsp(24'hFF0000, 24'h0, 24'h0, 24'h0, 3'd1, 1'b0));
        add_reg(CFG_WIDTH, 8'd1);
        add_reg(CFG_HEIGHT, 8'd1);
        add_beat(texel_write_beat(0, 1, 0, 9), 1'b0, '0);
        add_beat(sample_beat(0, 0, 128, 128, 1'b1), 1'b1,
                 mk_rsp(24'hFF0000, 24'h0, 24'h0, 24'h0, 3'd1, 1'b0));
        add_beat(sample_beat(1, 0, 0, 0, 1'b0), 1'b1,
                 mk_rsp(24'h0, 24'h0, 24'h0, 24'h0, 3'd1, 1'b1));
        add_beat(sample_beat(0, 1, 0, 0, 1'b1), 1'b1,
                 mk_rsp(24'h0, 24'h0, 24'h0, 24'h0, 3'd1, 1'b1));
        add_reg(CFG_CHANNELS, 8'd0);
        add_beat(sample_beat(0, 0, 64, 64, 1'b1), 1'b1,
                 mk_rsp(24'h0, 24'h0, 24'h0, 24'h0, 3'd0, 1'b0));
        add_reg(CFG_WIDTH, 8'd0);
        add_beat(sample_beat(0, 0, 0, 0, 1'b0), 1'b1,
                 mk_rsp(24'h0, 24'h0, 24'h0, 24'h0, 3'd0, 1'b1));
        // Register values above the maximum are limited to it.
        add_reg(CFG_WIDTH, 8'd255);
        add_reg(CFG_HEIGHT, 8'd255);
        add_reg(CFG_CHANNELS, 8'd7);
        add_beat(texel_write_beat(0, 0, 0, 8'hFF), 1'b0, '0);
        add_beat(texel_write_beat(1, 0, 0, 8'h0F), 1'b0, '0);
        add_beat(texel_write_beat(2, 0, 0, 8'hF0), 1'b0, '0);
        add_beat(texel_write_beat(3, 0, 0, 8'h55), 1'b0, '0);
        add_beat(sample_beat(0, 0, 0, 0, 1'b0), 1'b1,
                 mk_rsp(24'hFF0000, 24'h0F0000, 24'hF00000, 24'h550000, 3'd4, 1'b0));

        // Synchronous reset first.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.kind == ROW_REG) program_reg(row.idx, row.value);
            else send_beat(row.beat, row.typed, row.want);
        end

        // Random phases, each under its own register setting.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin w_val = 8'd128; h_val = 8'd128; nc_val = 3'd4; end
                1: begin w_val = 8'd1;   h_val = 8'd1;   nc_val = 3'd1; end
                2: begin w_val = 8'd255; h_val = 8'd2;   nc_val = 3'd7; end
                3: begin w_val = 8'd0;   h_val = 8'd128; nc_val = 3'd2; end
                4: begin w_val = 8'd2;   h_val = 8'd128; nc_val = 3'd0; end
                default: begin
                    r = $urandom_range(0, 5);
                    w_val = (r == 0) ? 8'd255 : (r == 1) ? 8'd1 : 8'($urandom_range(1, 128));
                    r = $urandom_range(0, 5);
                    h_val = (r == 0) ? 8'd255 : (r == 1) ? 8'd1 : 8'($urandom_range(1, 128));
                    nc_val = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                         : 3'($urandom_range(1, 4));
                end
            endcase
            program_reg(CFG_WIDTH, w_val);
            program_reg(CFG_HEIGHT, h_val);
            program_reg(CFG_CHANNELS, {5'd0, nc_val});
            // The last phase runs without idling on either side.
            src_gaps_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_stalls_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            bx = (act_w != 0) ? $urandom_range(0, act_w - 1) : 0;
            by = (act_h != 0) ? $urandom_range(0, act_h - 1) : 0;
            phase_end = accepted_items + PHASE_ITEMS;
            drained = 1'b0;
            while (accepted_items < phase_end) begin
                // Once, hold the sender until every awaited response is back.
                if (phase == 5 && !drained && accepted_items + PHASE_ITEMS / 2 >= phase_end) begin
                    drain_responses();
                    drained = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 12 || (pick < 20 && (act_w == 0 || act_h == 0 || act_nc == 0))) begin
                    // Noise write anywhere, often ignored.
                    send_beat(texel_write_beat($urandom_range(0, 3), $urandom_range(0, 127),
                                               $urandom_range(0, 127), $urandom_range(0, 255)),
                              1'b0, '0);
                end else if (pick < 20) begin
                    // Overwrite a texel near the current spot.
                    send_beat(texel_write_beat($urandom_range(0, act_nc - 1),
                                               (bx + $urandom_range(0, 3)) % act_w,
                                               (by + $urandom_range(0, 3)) % act_h,
                                               $urandom_range(0, 255)), 1'b0, '0);
                end else begin
                    // Sample, anywhere or near the current spot, after filling its texels.
                    if (pick < 32 || act_w == 0 || act_h == 0) begin
                        x = $urandom_range(0, 127);
                        y = $urandom_range(0, 127);
                    end else begin
                        x = (bx + $urandom_range(0, 3)) % act_w;
                        y = (by + $urandom_range(0, 3)) % act_h;
                    end
                    sm = $urandom_range(0, 1);
                    fill_neighborhood(x, y, sm);
                    send_beat(sample_beat(x, y, pick_weight(), pick_weight(), sm), 1'b0, '0);
                    if (pick % 10 == 0 && act_w != 0 && act_h != 0) begin
                        bx = $urandom_range(0, act_w - 1);
                        by = $urandom_range(0, act_h - 1);
                    end
                end
            end
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && awaited_samples.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tbs_pkg.sv
rtl/tbs_req_if.sv
rtl/tbs_rsp_if.sv
rtl/tbs_texel_ram.sv
rtl/texture_bilinear_sampler_unit.sv
tb/texture_bilinear_sampler_unit_tb.sv
